@@ rtl/a_star_open_set_engine_macros.svh @@
// Assertion macros for the A* open-set engine.
`ifndef A_STAR_OPEN_SET_ENGINE_MACROS_SVH
`define A_STAR_OPEN_SET_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define ASE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("label");
`define ASE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("label");
`else
`define ASE_ASSERT(label, clk, rst_n, prop)
`define ASE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/ase_pkg.sv @@
`timescale 1ns / 1ps
package ase_pkg;
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_POP   = 2'd1,
        MODE_NBR   = 2'd2,
        MODE_PATH  = 2'd3
    } t_mode;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_IMPROVED = 3'd2;
    localparam logic [2:0] ST_NOT_IMPR = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CURRD = 10'b0000000010,
        S_SCAN  = 10'b0000000100,
        S_SCANW = 10'b0000001000,
        S_NDEC  = 10'b0000010000,
        S_PRD   = 10'b0000100000,
        S_PWAIT = 10'b0001000000,
        S_PEMIT = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;
endpackage

@@ rtl/ase_ram.sv @@
`timescale 1ns / 1ps
module ase_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/a_star_open_set_engine.sv @@
`timescale 1ns / 1ps
`include "a_star_open_set_engine_macros.svh"
// A* open-set engine. Node ids, costs, totals and parent indexes live in one
// entry memory with a registered read; open marks are flip-flops.
// Start and a path on an empty table go from idle through the finish state
// to the output register. Pop scans the table one entry per cycle through
// the memory read port, then answers. Neighbor first reads the current
// entry, then scans, then answers. Path reads an entry, emits it as a word
// and follows its parent, waiting while the last word is not yet taken, up
// to MAX_NODES words. Results leave through a single output register; the
// input is ready again the cycle after the final word of the current command
// has been accepted.
module a_star_open_set_engine #(
    parameter int MAX_NODES = 64,
    parameter int ID_BITS   = 16,
    parameter int COST_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_node_id,
    input  logic [15:0] i_step_cost,
    input  logic [15:0] i_estimate,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result_id,
    output logic [23:0] o_cost_so_far,
    output logic [2:0]  o_status,
    output logic        o_last
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = IW + 1;
    localparam int PW = CW;
    localparam int EW = ID_BITS + 2 * COST_BITS + PW;
    localparam logic [COST_BITS-1:0] CMAX = {COST_BITS{1'b1}};
    localparam logic [PW-1:0] NO_PARENT = {PW{1'b1}};
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_NODES);

    ase_pkg::t_state r_state;
    logic [1:0]           r_mode;
    logic [ID_BITS-1:0]   r_id;
    logic [15:0]          r_step, r_est;
    logic [MAX_NODES-1:0] r_open;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        r_cur;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_rd_idx;
    logic                 r_scan_v;
    logic                 r_found;
    logic [IW-1:0]        r_best;
    logic [COST_BITS-1:0] r_best_tot, r_g, r_f;
    logic [COST_BITS-1:0] r_hit_cost, r_hit_tot;
    logic [IW-1:0]        r_hit;
    logic [CW-1:0]        r_nemit;

    logic [15:0]          r_o_id;
    logic [23:0]          r_o_cost;
    logic [2:0]           r_o_stat;
    logic                 r_o_last, r_o_valid;

    logic                 we;
    logic [IW-1:0]        waddr, raddr;
    logic [EW-1:0]        wdata, rdata;
    logic [ID_BITS-1:0]   rd_id;
    logic [COST_BITS-1:0] rd_cost, rd_tot;
    logic [PW-1:0]        rd_par;

    assign {rd_id, rd_cost, rd_tot, rd_par} = rdata;

    ase_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    function automatic logic [COST_BITS-1:0] sat_add(logic [COST_BITS-1:0] a,
                                                      logic [COST_BITS-1:0] b);
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? CMAX : s[COST_BITS-1:0];
    endfunction

    function automatic logic [COST_BITS-1:0] ext16(logic [15:0] v);
        logic [COST_BITS+15:0] w;
        w = {{COST_BITS{1'b0}}, v};
        return (w > {16'd0, CMAX}) ? CMAX : w[COST_BITS-1:0];
    endfunction

    logic in_fire, out_fire, busy_out;
    assign o_ready  = (r_state == ase_pkg::S_IDLE);
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_o_valid && i_ready;
    assign busy_out = r_o_valid && !i_ready;

    assign o_valid       = r_o_valid;
    assign o_result_id   = r_o_id;
    assign o_cost_so_far = r_o_cost;
    assign o_status      = r_o_stat;
    assign o_last        = r_o_last;

    // Read address: scans use the running index; path uses the walk pointer.
    assign raddr = r_rd_idx;

    logic [COST_BITS-1:0] nbr_g, nbr_f;
    assign nbr_g = sat_add(rd_cost, ext16(r_step));
    assign nbr_f = sat_add(nbr_g, ext16(r_est));

    logic scan_last;
    assign scan_last = ({1'b0, r_rd_idx} + CW'(1) >= r_count);

    // The walk ends at a parent outside the table or after MAX_NODES words.
    logic path_end;
    assign path_end = (rd_par >= r_count) || (r_nemit + CW'(1) >= CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ase_pkg::S_IDLE;
            r_open    <= '0;
            r_count   <= '0;
            r_cur     <= '0;
            r_o_valid <= 1'b0;
            r_scan_v  <= 1'b0;
        end else begin
            // The read port holds data for r_idx in the cycle after a scan read.
            r_scan_v <= (r_state == ase_pkg::S_SCAN);
            if (out_fire) r_o_valid <= 1'b0;
            case (r_state)
                ase_pkg::S_IDLE: begin
                    if (in_fire) begin
                        r_mode   <= i_mode;
                        r_id     <= ID_BITS'(i_node_id);
                        r_step   <= i_step_cost;
                        r_est    <= i_estimate;
                        r_found  <= 1'b0;
                        r_nemit  <= '0;
                        case (ase_pkg::t_mode'(i_mode))
                            ase_pkg::MODE_START: begin
                                r_open    <= MAX_NODES'(1);
                                r_count   <= CW'(1);
                                r_cur     <= '0;
                                r_o_id    <= 16'(ID_BITS'(i_node_id));
                                r_o_cost  <= '0;
                                r_o_stat  <= ase_pkg::ST_DONE;
                                r_state   <= ase_pkg::S_FIN;
                            end
                            ase_pkg::MODE_POP: begin
                                r_rd_idx <= '0;
                                r_state  <= (r_count == '0) ? ase_pkg::S_SCANW
                                                            : ase_pkg::S_SCAN;
                            end
                            ase_pkg::MODE_NBR: begin
                                r_rd_idx <= r_cur;
                                r_state  <= ase_pkg::S_CURRD;
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_o_id   <= '0;
                                    r_o_cost <= '0;
                                    r_o_stat <= ase_pkg::ST_DONE;
                                    r_state  <= ase_pkg::S_FIN;
                                end else begin
                                    r_rd_idx <= r_cur;
                                    r_state  <= ase_pkg::S_PWAIT;
                                end
                            end
                        endcase
                    end
                end
                // Neighbor: the current entry is being read.
                ase_pkg::S_CURRD: begin
                    r_state  <= ase_pkg::S_NDEC;
                    r_rd_idx <= '0;
                end
                // Neighbor: current entry data arrives, compute g and f.
                ase_pkg::S_NDEC: begin
                    r_g <= nbr_g;
                    r_f <= nbr_f;
                    if (r_count == '0) begin
                        r_state <= ase_pkg::S_SCANW;
                    end else begin
                        r_state <= ase_pkg::S_SCAN;
                    end
                end
                // Scan issues reads for indexes 0..count-1, compares in the cycle after.
                ase_pkg::S_SCAN: begin
                    r_idx <= r_rd_idx;
                    if (scan_last) begin
                        r_state <= ase_pkg::S_SCANW;
                    end else begin
                        r_rd_idx <= r_rd_idx + IW'(1);
                    end
                end
                ase_pkg::S_SCANW: begin
                    r_state <= ase_pkg::S_PEMIT;
                end
                ase_pkg::S_PWAIT: r_state <= ase_pkg::S_PRD;
                ase_pkg::S_PRD: begin
                    if (!r_o_valid) begin
                        r_o_id    <= 16'(rd_id);
                        r_o_cost  <= 24'(rd_cost);
                        r_o_stat  <= ase_pkg::ST_DONE;
                        r_o_last  <= path_end;
                        r_o_valid <= 1'b1;
                        r_nemit   <= r_nemit + CW'(1);
                        if (path_end) begin
                            r_state <= ase_pkg::S_OUT;
                        end else begin
                            r_rd_idx <= rd_par[IW-1:0];
                            r_state  <= ase_pkg::S_PWAIT;
                        end
                    end
                end
                ase_pkg::S_PEMIT: begin
                    r_state <= ase_pkg::S_FIN;
                    if (ase_pkg::t_mode'(r_mode) == ase_pkg::MODE_POP) begin
                        if (!r_found) begin
                            r_o_id   <= '0;
                            r_o_cost <= '0;
                            r_o_stat <= ase_pkg::ST_EMPTY;
                        end else begin
                            r_open[r_best] <= 1'b0;
                            r_cur          <= r_best;
                            r_o_id         <= 16'(r_id);
                            r_o_cost       <= 24'(r_g);
                            r_o_stat       <= ase_pkg::ST_DONE;
                        end
                    end else begin
                        r_o_id <= 16'(r_id);
                        if (!r_found) begin
                            if (r_count >= CNT_MAX) begin
                                r_o_cost <= '0;
                                r_o_stat <= ase_pkg::ST_FULL;
                            end else begin
                                r_open[r_count[IW-1:0]] <= 1'b1;
                                r_count  <= r_count + CW'(1);
                                r_o_cost <= 24'(r_g);
                                r_o_stat <= ase_pkg::ST_INSERTED;
                            end
                        end else begin
                            r_open[r_hit] <= 1'b1;
                            if (r_f < r_hit_tot) begin
                                r_o_cost <= 24'(r_g);
                                r_o_stat <= ase_pkg::ST_IMPROVED;
                            end else begin
                                r_o_cost <= 24'(r_hit_cost);
                                r_o_stat <= ase_pkg::ST_NOT_IMPR;
                            end
                        end
                    end
                end
                ase_pkg::S_FIN: begin
                    if (!r_o_valid) begin
                        r_o_valid <= 1'b1;
                        r_o_last  <= 1'b1;
                        r_state   <= ase_pkg::S_OUT;
                    end
                end
                ase_pkg::S_OUT: begin
                    if (out_fire) r_state <= ase_pkg::S_IDLE;
                end
                default: r_state <= ase_pkg::S_IDLE;
            endcase

            // Compare stage of the scan: data for r_idx is on the read port.
            if (r_scan_v) begin
                if (ase_pkg::t_mode'(r_mode) == ase_pkg::MODE_POP) begin
                    if (r_open[r_idx] && (!r_found || rd_tot < r_best_tot)) begin
                        r_found    <= 1'b1;
                        r_best     <= r_idx;
                        r_best_tot <= rd_tot;
                        r_id       <= rd_id;
                        r_g        <= rd_cost;
                    end
                end else if (!r_found && rd_id == r_id) begin
                    r_found    <= 1'b1;
                    r_hit      <= r_idx;
                    r_hit_cost <= rd_cost;
                    r_hit_tot  <= rd_tot;
                end
            end
        end
    end

    // Table writes: start fills entry 0, neighbor inserts or improves.
    logic nbr_commit_ins, nbr_commit_imp;
    assign nbr_commit_ins = (r_state == ase_pkg::S_PEMIT) &&
                            (ase_pkg::t_mode'(r_mode) == ase_pkg::MODE_NBR) &&
                            !r_found && (r_count < CNT_MAX);
    assign nbr_commit_imp = (r_state == ase_pkg::S_PEMIT) &&
                            (ase_pkg::t_mode'(r_mode) == ase_pkg::MODE_NBR) &&
                            r_found && (r_f < r_hit_tot);
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = {r_id, r_g, r_f, {1'b0, r_cur}};
        if (in_fire && ase_pkg::t_mode'(i_mode) == ase_pkg::MODE_START) begin
            we    = 1'b1;
            wdata = {ID_BITS'(i_node_id), {COST_BITS{1'b0}},
                     ext16(i_estimate), NO_PARENT};
        end else if (nbr_commit_ins) begin
            we    = 1'b1;
            waddr = r_count[IW-1:0];
        end else if (nbr_commit_imp) begin
            we    = 1'b1;
            waddr = r_hit;
        end
    end

    `ASE_ASSERT(a_out_hold, i_clk, i_rst_n, busy_out |=> r_o_valid && $stable({r_o_id, r_o_cost, r_o_stat, r_o_last}))
    `ASE_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_MAX)
    `ASE_ASSERT(a_state_hot, i_clk, i_rst_n, $onehot(r_state))
    `ASE_ASSERT(a_no_accept_busy, i_clk, i_rst_n, r_o_valid |-> !o_ready)
endmodule
